// ===== rtl/stef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stef_pkg: shared types for the spanning tree edge filter
// Transaction payloads, the token that walks the label cell chain, and the
// controller state encoding.
// ----------------------------------------------------------------------------
package stef_pkg;

  localparam int NODE_W   = 6;
  localparam int LABEL_W  = 7;
  localparam int COUNT_W  = 7;
  localparam int WEIGHT_W = 16;
  localparam int POS_W    = 12;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   end_a;
    logic [NODE_W-1:0]   end_b;
    logic [WEIGHT_W-1:0] weight;
    logic                last_edge;
  } stef_in_t;

  typedef struct packed {
    logic                accepted;
    logic [POS_W-1:0]    edge_position;
    logic [NODE_W-1:0]   out_a;
    logic [NODE_W-1:0]   out_b;
    logic [WEIGHT_W-1:0] out_weight;
    logic                tree_complete;
  } stef_out_t;

  typedef enum logic {
    OP_PROBE  = 1'b0,
    OP_UPDATE = 1'b1
  } stef_op_t;

  typedef struct packed {
    logic               valid;
    stef_op_t           op;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [LABEL_W-1:0] label_a;
    logic [LABEL_W-1:0] label_b;
    logic               wr_a;
    logic               wr_b;
    logic [LABEL_W-1:0] wr_val;
    logic               merge;
    logic [COUNT_W-1:0] node_lim;
  } stef_token_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PROBE  = 2'd1,
    ST_UPDATE = 2'd2
  } stef_state_t;

endpackage
`default_nettype wire

// ===== rtl/spanning_tree_edge_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spanning_tree_edge_filter: Kruskal edge filter with component labels
// Edges arrive sorted by length; each one is accepted into the spanning
// forest or rejected, using one label per node held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. Command
// start clears all labels and counters and gives no result.
// Command edge gives one result on out_data, marked by out_strobe for one
// cycle; the receiver cannot stall and must take it then.
// An edge rejected without a label lookup (tree complete, end out of range,
// self loop) gives its result in the next cycle and busy stays low.
// Otherwise a probe token walks the MAX_NODES label cells to fetch both end
// labels, and the result is registered once the token returns. A rejected
// edge then frees the block; an accepted edge sends an update token down the
// chain, and busy stays high until that token returns.
// cfg_wr_data sets the node count (reset 64); write it only while idle.
// Reset clears all labels, counters and the result strobe.
// ----------------------------------------------------------------------------
module spanning_tree_edge_filter #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 4096
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  stef_pkg::stef_in_t          in_data,
  output logic                        out_strobe,
  output stef_pkg::stef_out_t         out_data,
  input  wire                         cfg_wr_en,
  input  wire [stef_pkg::COUNT_W-1:0] cfg_wr_data
);

  stef_pkg::stef_token_t tok [MAX_NODES+1];
  logic                  clear;

  stef_ctrl #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .clear      (clear),
    .tok_launch (tok[0]),
    .tok_ret    (tok[MAX_NODES])
  );

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    stef_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clear  (clear),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/stef_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stef_cell: one node label cell
// Holds the component label of node IDX. A token passes through each cycle;
// a probe token picks up the label, an update token rewrites it.
// ----------------------------------------------------------------------------
module stef_cell #(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 clear,
  input  stef_pkg::stef_token_t tok_in,
  output stef_pkg::stef_token_t tok_out
);

  logic [stef_pkg::LABEL_W-1:0] label_r;
  logic [stef_pkg::LABEL_W-1:0] label_nxt;
  stef_pkg::stef_token_t        tok_r;
  stef_pkg::stef_token_t        tok_nxt;
  logic                         hit_a;
  logic                         hit_b;
  logic                         in_range;

  always_comb begin
    hit_a     = (IDX == int'(tok_in.node_a));
    hit_b     = (IDX == int'(tok_in.node_b));
    in_range  = (IDX < int'(tok_in.node_lim));
    label_nxt = label_r;
    tok_nxt   = tok_in;
    if (clear) begin
      label_nxt = '0;
    end else if (tok_in.valid) begin
      if (tok_in.op == stef_pkg::OP_PROBE) begin
        if (hit_a) begin
          tok_nxt.label_a = label_r;
        end
        if (hit_b) begin
          tok_nxt.label_b = label_r;
        end
      end else begin
        // merge: every node of the second component takes the first label
        if (tok_in.merge && in_range && label_r == tok_in.label_b) begin
          label_nxt = tok_in.label_a;
        end
        if ((tok_in.wr_a && hit_a) || (tok_in.wr_b && hit_b)) begin
          label_nxt = tok_in.wr_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= '0;
      tok_r   <= '0;
    end else begin
      label_r <= label_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// ===== rtl/stef_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stef_ctrl: edge filter controller
// Takes transactions, launches probe and update tokens into the label chain,
// decides on each edge and drives the result register.
// ----------------------------------------------------------------------------
module stef_ctrl #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  stef_pkg::stef_in_t                  in_data,
  output logic                                out_strobe,
  output stef_pkg::stef_out_t                 out_data,
  input  wire                                 cfg_wr_en,
  input  wire [stef_pkg::COUNT_W-1:0]         cfg_wr_data,
  output logic                                clear,
  output stef_pkg::stef_token_t               tok_launch,
  input  stef_pkg::stef_token_t               tok_ret
);

  localparam int CNT_W = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;

  stef_pkg::stef_state_t          state_r, state_nxt;
  logic [stef_pkg::LABEL_W-1:0]   tree_size_r, tree_size_nxt;
  logic [CNT_W-1:0]               edge_cnt_r, edge_cnt_nxt;
  logic                           list_ended_r, list_ended_nxt;
  stef_pkg::stef_in_t             edge_r, edge_nxt;
  logic [CNT_W-1:0]               pos_r, pos_nxt;
  logic                           last_r, last_nxt;
  logic                           out_strobe_r, out_strobe_nxt;
  stef_pkg::stef_out_t            out_data_r, out_data_nxt;
  logic [stef_pkg::COUNT_W-1:0]   node_count_r;

  logic [stef_pkg::COUNT_W-1:0]   n_use;
  logic                           at_lim;
  logic                           last_in;
  logic                           eligible;
  logic                           ends_ok;
  logic                           acc;
  logic [stef_pkg::LABEL_W-1:0]   la;
  logic [stef_pkg::LABEL_W-1:0]   lb;
  logic [stef_pkg::LABEL_W-1:0]   fresh;

  always_comb begin
    n_use    = (int'(node_count_r) > MAX_NODES) ? stef_pkg::COUNT_W'(MAX_NODES) : node_count_r;
    at_lim   = (edge_cnt_r == CNT_W'(MAX_EDGES - 1));
    last_in  = in_data.last_edge | at_lim;
    eligible = (tree_size_r < n_use) && !list_ended_r;
    ends_ok  = ({1'b0, in_data.end_a} < n_use) && ({1'b0, in_data.end_b} < n_use) &&
               (in_data.end_a != in_data.end_b);
    la       = tok_ret.label_a;
    lb       = tok_ret.label_b;
    fresh    = tree_size_r + stef_pkg::LABEL_W'(1);
    acc      = 1'b0;

    state_nxt      = state_r;
    tree_size_nxt  = tree_size_r;
    edge_cnt_nxt   = edge_cnt_r;
    list_ended_nxt = list_ended_r;
    edge_nxt       = edge_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    clear          = 1'b0;
    tok_launch     = '0;
    tok_launch.node_a   = edge_r.end_a;
    tok_launch.node_b   = edge_r.end_b;
    tok_launch.node_lim = n_use;

    case (state_r)
      stef_pkg::ST_IDLE: begin
        if (start) begin
          if (in_data.command == stef_pkg::CMD_START) begin
            clear          = 1'b1;
            tree_size_nxt  = stef_pkg::LABEL_W'(1);
            edge_cnt_nxt   = '0;
            list_ended_nxt = 1'b0;
          end else begin
            if (!at_lim) begin
              edge_cnt_nxt = edge_cnt_r + CNT_W'(1);
            end
            edge_nxt = in_data;
            pos_nxt  = edge_cnt_r;
            last_nxt = last_in;
            if (eligible && ends_ok) begin
              tok_launch.valid  = 1'b1;
              tok_launch.op     = stef_pkg::OP_PROBE;
              tok_launch.node_a = in_data.end_a;
              tok_launch.node_b = in_data.end_b;
              state_nxt         = stef_pkg::ST_PROBE;
            end else begin
              // rejected without a label lookup
              list_ended_nxt             = list_ended_r | (eligible & last_in);
              out_strobe_nxt             = 1'b1;
              out_data_nxt.accepted      = 1'b0;
              out_data_nxt.edge_position = stef_pkg::POS_W'(edge_cnt_r);
              out_data_nxt.out_a         = in_data.end_a;
              out_data_nxt.out_b         = in_data.end_b;
              out_data_nxt.out_weight    = in_data.weight;
              out_data_nxt.tree_complete = (tree_size_r >= n_use) || list_ended_nxt;
            end
          end
        end
      end
      stef_pkg::ST_PROBE: begin
        if (tok_ret.valid) begin
          tok_launch.op = stef_pkg::OP_UPDATE;
          tok_launch.label_a = la;
          tok_launch.label_b = lb;
          if (la == '0) begin
            acc               = 1'b1;
            tok_launch.wr_a   = 1'b1;
            tok_launch.wr_b   = (lb == '0);
            tok_launch.wr_val = (lb == '0) ? fresh : lb;
          end else if (lb == '0) begin
            acc               = 1'b1;
            tok_launch.wr_b   = 1'b1;
            tok_launch.wr_val = la;
          end else if (la != lb) begin
            acc              = 1'b1;
            tok_launch.merge = 1'b1;
          end
          if (acc) begin
            tree_size_nxt    = fresh;
            tok_launch.valid = 1'b1;
            state_nxt        = stef_pkg::ST_UPDATE;
          end else begin
            state_nxt = stef_pkg::ST_IDLE;
          end
          list_ended_nxt             = list_ended_r | last_r;
          out_strobe_nxt             = 1'b1;
          out_data_nxt.accepted      = acc;
          out_data_nxt.edge_position = stef_pkg::POS_W'(pos_r);
          out_data_nxt.out_a         = edge_r.end_a;
          out_data_nxt.out_b         = edge_r.end_b;
          out_data_nxt.out_weight    = edge_r.weight;
          out_data_nxt.tree_complete = (tree_size_nxt >= n_use) || list_ended_nxt;
        end
      end
      stef_pkg::ST_UPDATE: begin
        if (tok_ret.valid) begin
          state_nxt = stef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stef_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= stef_pkg::ST_IDLE;
      tree_size_r  <= stef_pkg::LABEL_W'(1);
      edge_cnt_r   <= '0;
      list_ended_r <= 1'b0;
      out_strobe_r <= 1'b0;
      node_count_r <= stef_pkg::COUNT_W'(64);
    end else begin
      state_r      <= state_nxt;
      tree_size_r  <= tree_size_nxt;
      edge_cnt_r   <= edge_cnt_nxt;
      list_ended_r <= list_ended_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    edge_r     <= edge_nxt;
    pos_r      <= pos_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != stef_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire
